// File: sv/kpfq_pkg.sv
// ----------------------------------------------------------------------------
// kpfq_pkg: shared types and constants of the keyframe priority frame queue
// Holds the beat payload types, the stored slot type, status codes,
// action codes and configuration register indexes.
// ----------------------------------------------------------------------------
package kpfq_pkg;

  // Built queue depth by default and fixed field widths.
  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned REF_BITS      = 16;
  localparam int unsigned SIZE_BITS     = 24;
  localparam int unsigned CAP_W         = 6;
  localparam int unsigned QDEPTH_W      = 6;
  localparam int unsigned CNT32_W       = 32;
  localparam int unsigned BYTES_W       = 48;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CAP_W;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_KEY = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Action codes carried by an input beat.
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_SERVICE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_EVICTED    = 3'd1,
    ST_DROP_FULL  = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_SENT       = 3'd4,
    ST_DROP_WAIT  = 3'd5,
    ST_CONN_FAIL  = 3'd6,
    ST_SEND_FAIL  = 3'd7
  } status_t;

  // Input beat.
  typedef struct packed {
    logic                 action;
    logic [REF_BITS-1:0]  frame_ref;
    logic                 is_key;
    logic [SIZE_BITS-1:0] byte_size;
    logic                 connect_ok;
    logic                 send_ok;
  } in_t;

  // Result beat.
  typedef struct packed {
    status_t              status;
    logic [REF_BITS-1:0]  out_ref;
    logic [SIZE_BITS-1:0] out_size;
    logic                 out_key;
    logic [QDEPTH_W-1:0]  fill_level;
    logic                 link_up;
    logic                 awaiting_key;
    logic [CNT32_W-1:0]   dropped_count;
    logic [CNT32_W-1:0]   sent_count;
    logic [BYTES_W-1:0]   byte_total;
    logic [CNT32_W-1:0]   failure_count;
    logic [CNT32_W-1:0]   connect_total;
  } out_t;

  // One stored frame descriptor.
  typedef struct packed {
    logic                 key;
    logic [REF_BITS-1:0]  ref_h;
    logic [SIZE_BITS-1:0] size;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// File: sv/keyframe_priority_frame_queue.sv
// ----------------------------------------------------------------------------
// keyframe_priority_frame_queue: bounded frame descriptor queue with drop policy
// Path: an accepted beat is held in the input register, then its result is registered in the result register.
// Throughput: one beat per cycle while out_stall does not hold the result; a beat does at most one slot-memory write.
// Reset: pointers, link state, key wait and counters clear; capacity is 32,
// key wait after connect is off; slot memory is not cleared.
// ----------------------------------------------------------------------------
module keyframe_priority_frame_queue
  import kpfq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              s1_valid_r, s1_valid_nxt;
  in_t               s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;
  logic [CAP_W-1:0]  cap_r;
  logic              wait_key_r;
  logic              fire;
  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [SLOT_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [SLOT_W-1:0] rd_data;
  out_t              result;

  // Handshake: the held beat moves on when the result register is free.
  assign fire      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !fire;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      wait_key_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CAPACITY: cap_r      <= cfg_data;
          REG_WAIT_KEY: wait_key_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  kpfq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (s1_data_r),
    .cfg_capacity (cap_r),
    .cfg_wait_key (wait_key_r),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result       (result)
  );

  kpfq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: sv/kpfq_ram.sv
// ----------------------------------------------------------------------------
// kpfq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read of
// the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module kpfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/kpfq_ctrl.sv
// ----------------------------------------------------------------------------
// kpfq_ctrl: queue pointers, drop policy, link state and counters
// Decides the outcome of the beat held in the input register in one pass,
// drives the slot memory ports and builds the result beat.
// ----------------------------------------------------------------------------
module kpfq_ctrl
  import kpfq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  in_t                                   item,
  input  logic [CAP_W-1:0]                      cfg_capacity,
  input  logic                                  cfg_wait_key,
  output logic                                  wr_en,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output logic [SLOT_W-1:0]                     wr_data,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic [SLOT_W-1:0]                     rd_data,
  output out_t                                  result
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Reduce a sum below twice the depth into a ring address.
  function automatic logic [AW-1:0] ring_wrap(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] w;
    begin
      w = v;
      if (v >= SUM_W'(DEPTH)) begin
        w = v - SUM_W'(DEPTH);
      end
      return AW'(w);
    end
  endfunction

  logic [AW-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               linked_r, linked_nxt;
  logic               key_wait_r, key_wait_nxt;
  logic [CNT32_W-1:0] drop_r, drop_nxt;
  logic [CNT32_W-1:0] sent_r, sent_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [CNT32_W-1:0] fail_r, fail_nxt;
  logic [CNT32_W-1:0] conn_r, conn_nxt;
  logic               byp_hit_r;
  slot_t              byp_data_r;

  logic [CMP_W-1:0]   cap_ext;
  logic [CNT_W-1:0]   cap_eff;
  logic               full;
  logic [CNT_W-1:0]   evict_n;
  logic [AW-1:0]      tail_addr;
  logic [AW-1:0]      head_evict;
  logic [AW-1:0]      head_inc;
  slot_t              slot;
  slot_t              new_slot;
  status_t            status;
  logic               popped;
  logic               done;
  logic               wr_req;

  // Effective capacity: zero or above the built depth means the full depth.
  always_comb begin
    cap_ext = CMP_W'(cfg_capacity);
    if (cap_ext == '0 || cap_ext > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_ext);
    end
  end

  // Ring arithmetic. The tail is the same before and after an eviction.
  assign full       = (count_r >= cap_eff);
  assign evict_n    = count_r - cap_eff + CNT_W'(1);
  assign tail_addr  = ring_wrap(SUM_W'(head_r) + SUM_W'(count_r));
  assign head_evict = ring_wrap(SUM_W'(head_r) + SUM_W'(evict_n));
  assign head_inc   = ring_wrap(SUM_W'(head_r) + SUM_W'(1));

  // Head slot, taking the last write when it landed on the slot being read.
  assign slot = byp_hit_r ? byp_data_r : slot_t'(rd_data);

  always_comb begin
    new_slot.key   = item.is_key;
    new_slot.ref_h = item.frame_ref;
    new_slot.size  = item.byte_size;
  end

  // Policy decision for the held beat.
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    linked_nxt   = linked_r;
    key_wait_nxt = key_wait_r;
    drop_nxt     = drop_r;
    sent_nxt     = sent_r;
    bytes_nxt    = bytes_r;
    fail_nxt     = fail_r;
    conn_nxt     = conn_r;
    status       = ST_QUEUED;
    popped       = 1'b0;
    done         = 1'b0;
    wr_req       = 1'b0;

    if (item.action == ACT_ENQUEUE) begin
      if (full && !item.is_key) begin
        drop_nxt = drop_r + CNT32_W'(1);
        status   = ST_DROP_FULL;
      end else begin
        wr_req = 1'b1;
        if (full) begin
          // Evict the oldest entries until the new frame fits.
          head_nxt  = head_evict;
          drop_nxt  = drop_r + CNT32_W'(evict_n);
          count_nxt = cap_eff;
          status    = ST_EVICTED;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end else if (count_r == '0) begin
      status = ST_EMPTY;
    end else begin
      popped    = 1'b1;
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
      // Connect first when the link is down.
      if (!linked_r) begin
        if (item.connect_ok) begin
          linked_nxt   = 1'b1;
          key_wait_nxt = cfg_wait_key;
          conn_nxt     = conn_r + CNT32_W'(1);
        end else begin
          status = ST_CONN_FAIL;
          done   = 1'b1;
        end
      end
      // Non-key frames are dropped while waiting for a key frame.
      if (!done && key_wait_nxt && !slot.key) begin
        drop_nxt = drop_r + CNT32_W'(1);
        status   = ST_DROP_WAIT;
        done     = 1'b1;
      end
      if (!done) begin
        key_wait_nxt = 1'b0;
        if (!item.send_ok) begin
          linked_nxt   = 1'b0;
          key_wait_nxt = cfg_wait_key;
          fail_nxt     = fail_r + CNT32_W'(1);
          status       = ST_SEND_FAIL;
        end else begin
          sent_nxt  = sent_r + CNT32_W'(1);
          bytes_nxt = bytes_r + BYTES_W'(slot.size);
          status    = ST_SENT;
        end
      end
    end
  end

  // Memory ports. The read address runs one beat ahead of the decision.
  assign wr_en   = fire && wr_req;
  assign wr_addr = tail_addr;
  assign wr_data = new_slot;
  assign rd_addr = fire ? head_nxt : head_r;

  // Result beat.
  always_comb begin
    result.status        = status;
    result.out_ref       = popped ? slot.ref_h : '0;
    result.out_size      = popped ? slot.size : '0;
    result.out_key       = popped ? slot.key : 1'b0;
    result.fill_level    = QDEPTH_W'(count_nxt);
    result.link_up       = linked_nxt;
    result.awaiting_key  = key_wait_nxt;
    result.dropped_count = drop_nxt;
    result.sent_count    = sent_nxt;
    result.byte_total    = bytes_nxt;
    result.failure_count = fail_nxt;
    result.connect_total = conn_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      linked_r   <= 1'b0;
      key_wait_r <= 1'b0;
      drop_r     <= '0;
      sent_r     <= '0;
      bytes_r    <= '0;
      fail_r     <= '0;
      conn_r     <= '0;
      byp_hit_r  <= 1'b0;
    end else begin
      byp_hit_r <= wr_en && (wr_addr == rd_addr);
      if (fire) begin
        head_r     <= head_nxt;
        count_r    <= count_nxt;
        linked_r   <= linked_nxt;
        key_wait_r <= key_wait_nxt;
        drop_r     <= drop_nxt;
        sent_r     <= sent_nxt;
        bytes_r    <= bytes_nxt;
        fail_r     <= fail_nxt;
        conn_r     <= conn_nxt;
      end
    end
  end

  // Write data kept for the read-after-write bypass.
  always_ff @(posedge clk) begin
    byp_data_r <= new_slot;
  end

endmodule
